@@ rtl/core/plic_pkg.sv @@
// Package for the platform interrupt controller: sizes, address map, codes, states.
// No dependencies.
`timescale 1ns / 1ps
package plic_pkg;
    localparam int NumSrc  = 63;
    localparam int NumCtx  = 8;
    localparam int PrioW   = 3;
    localparam int SrcW    = 6;
    localparam int CtxW    = 3;
    localparam int SrcWords = (NumSrc + 32) / 32;
    localparam int WordW   = (SrcWords > 1) ? $clog2(SrcWords) : 1;
    localparam int NSrcBits = SrcWords * 32;

    localparam logic [25:0] PendBase = 26'h1000;
    localparam logic [25:0] EnBase   = 26'h2000;
    localparam logic [25:0] CtxBase  = 26'h200000;

    typedef enum logic [1:0] {
        FN_READ   = 2'd0,
        FN_WRITE  = 2'd1,
        FN_LEVEL  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLAIM,
        ST_LINES,
        ST_DONE
    } t_state;

    // request to the scan unit
    typedef struct packed {
        logic            go;
    } t_scan_req;

    typedef struct packed {
        logic            done;
        logic [SrcW-1:0] best;
    } t_scan_rsp;
endpackage

@@ rtl/core/plic_scan.sv @@
// Shared compare unit: walks the sources of one context, one source a cycle.
// Depends on plic_pkg.
`timescale 1ns / 1ps
module plic_scan import plic_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_scan_req            i_req,
    input  logic [NSrcBits-1:0]  i_pend,
    input  logic [NSrcBits-1:0]  i_en,
    input  logic [PrioW-1:0]     i_thr,
    input  logic [PrioW-1:0]     i_prio,
    output logic [SrcW-1:0]      o_idx,
    output t_scan_rsp            o_rsp
);
    logic            r_run, n_run;
    logic [SrcW-1:0] r_id, n_id;
    logic [SrcW-1:0] r_best, n_best;
    logic [PrioW-1:0] r_bp, n_bp;
    logic            r_first, n_first;
    logic            r_done, n_done;
    logic [PrioW-1:0] cur_bp;
    logic            hit;

    // priority store read address: the source compared next cycle
    assign o_idx = n_id;
    // threshold taken in the first compare cycle, after the access has landed
    assign cur_bp = r_first ? i_thr : r_bp;
    assign hit = i_pend[r_id] && i_en[r_id] && (i_prio > cur_bp);

    always_comb begin
        n_run = r_run; n_id = r_id; n_best = r_best; n_bp = r_bp; n_first = r_first;
        n_done = 1'b0;
        if (i_req.go) begin
            n_run = 1'b1; n_id = SrcW'(1); n_best = '0; n_first = 1'b1;
        end else if (r_run) begin
            n_first = 1'b0;
            n_bp = hit ? i_prio : cur_bp;
            if (hit) begin
                n_best = r_id;
            end
            if (r_id == SrcW'(NumSrc)) begin
                n_run = 1'b0; n_done = 1'b1;
            end else begin
                n_id = r_id + SrcW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; r_done <= 1'b0;
        end else begin
            r_run <= n_run; r_done <= n_done;
        end
        r_id <= n_id; r_best <= n_best; r_bp <= n_bp; r_first <= n_first;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.best = r_best;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_run)
        else $error("scan done while running");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && !i_req.go) |-> (r_id != '0))
        else $error("scan at source zero");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_run))
        else $error("done without scan");
endmodule

@@ rtl/core/platform_interrupt_controller.sv @@
// Top level: register window, gateway, sequencer; uses plic_scan and plic_pkg.
// Register storage lives here; claim and line evaluation share one scan unit.
`timescale 1ns / 1ps
// A word is taken when start is high and busy low. After reset busy stays high
// while the priority store is cleared. A claim read adds one more scan to the
// work of a level update or a plain register access: every access ends with one
// pass of the shared scan unit (one source per cycle) per context to refresh
// o_irq_lines. The result shows for one cycle with o_done and cannot be held off
// by the receiver.
module platform_interrupt_controller import plic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [25:0] i_offset,
    input  logic [31:0] i_wdata,
    input  logic [5:0]  i_source,
    input  logic        i_level,
    output logic        o_done,
    output logic [31:0] o_rdata,
    output logic [7:0]  o_irq_lines,
    output logic        o_bad_access
);
    logic [PrioW-1:0]   r_prio [NumSrc+1];
    logic [PrioW-1:0]   r_prio_q;
    logic [SrcW-1:0]    r_clr;
    logic [31:0]        r_en   [NumCtx*SrcWords];
    logic [PrioW-1:0]   r_thr  [NumCtx];
    logic [NSrcBits-1:0] r_pend, r_isv, r_lvl;
    t_state             r_st, n_st;
    logic [CtxW-1:0]    r_ctx, r_cctx;
    logic [7:0]         r_lines;
    logic [31:0]        r_rdata;
    logic               r_bad, r_done;

    t_scan_req          req;
    t_scan_rsp          rsp;
    logic [SrcW-1:0]    sidx;
    logic [CtxW-1:0]    sctx;
    logic [NSrcBits-1:0] en_vec;

    // decode
    logic        acc, wr, mis, is_pri, is_pen, is_en, is_ctx, ctx_ok;
    logic [23:0] pid;
    logic [10:0] pw;
    logic [20:0] erel;
    logic [13:0] ec;
    logic [4:0]  ew;
    logic [20:0] cc;
    logic [11:0] cr;
    always_comb begin
        acc = (i_func == FN_READ) || (i_func == FN_WRITE);
        wr  = (i_func == FN_WRITE);
        pid = i_offset[25:2];
        pw  = 11'((i_offset - PendBase) >> 2);
        erel = 21'(i_offset - EnBase);
        ec  = erel[20:7];
        ew  = erel[6:2];
        cc  = 21'((i_offset - CtxBase) >> 12);
        cr  = i_offset[11:0];
        is_pri = i_offset < PendBase;
        is_pen = !is_pri && i_offset < EnBase;
        is_en  = !is_pri && !is_pen && i_offset < CtxBase;
        is_ctx = !is_pri && !is_pen && !is_en;
        ctx_ok = (cc < 21'(NumCtx)) && (cr == 12'h0 || cr == 12'h4);
        mis = (i_offset[1:0] != 2'b0)
            || (is_pri && pid > 24'(NumSrc))
            || (is_pen && pw >= 11'(SrcWords))
            || (is_en && (ec >= 14'(NumCtx) || ew >= 5'(SrcWords)))
            || (is_ctx && !ctx_ok);
    end

    function automatic logic [31:0] vmask(input int w);
        logic [31:0] m;
        m = '0;
        for (int b = 0; b < 32; b++)
            if (w*32+b >= 1 && w*32+b <= NumSrc) m[b] = 1'b1;
        return m;
    endfunction

    assign sctx = (r_st == ST_CLAIM) ? r_cctx : r_ctx;
    always_comb
        for (int w = 0; w < SrcWords; w++)
            en_vec[w*32 +: 32] = r_en[int'(sctx)*SrcWords + w];

    plic_scan u_scan (
        .i_clk, .i_rst_n, .i_req(req), .i_pend(r_pend), .i_en(en_vec),
        .i_thr(r_thr[sctx]), .i_prio(r_prio_q), .o_idx(sidx), .o_rsp(rsp)
    );

    logic take;
    assign take = start && !busy;
    logic last_ctx;
    assign last_ctx = (r_ctx == CtxW'(NumCtx-1));

    // priority store: cleared by a pass after reset, one registered scan read
    logic prio_we;
    assign prio_we = take && wr && !mis && is_pri && pid != 24'd0;

    always_ff @(posedge i_clk) begin
        if (r_st == ST_CLEAR) r_prio[r_clr] <= '0;
        else if (prio_we) r_prio[pid[SrcW-1:0]] <= i_wdata[PrioW-1:0];
        // bypass so a scan started by this write sees the new priority
        if (prio_we && pid[SrcW-1:0] == sidx) r_prio_q <= i_wdata[PrioW-1:0];
        else r_prio_q <= r_prio[sidx];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_CLEAR: if (r_clr == SrcW'(NumSrc)) n_st = ST_IDLE;
            ST_IDLE:  if (take) n_st = (acc && !wr && !mis && is_ctx && cr == 12'h4)
                                       ? ST_CLAIM : ST_LINES;
            ST_CLAIM: if (rsp.done) n_st = ST_LINES;
            ST_LINES: if (rsp.done && last_ctx) n_st = ST_DONE;
            ST_DONE:  n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        busy = (r_st != ST_IDLE);
        unique case (r_st)
            ST_IDLE:  req.go = take;
            ST_CLAIM: req.go = rsp.done;
            ST_LINES: req.go = rsp.done && !last_ctx;
            default:  req.go = 1'b0;
        endcase
    end

    logic [SrcW-1:0] cid;
    assign cid = i_wdata[SrcW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_clr <= '0;
            r_done <= 1'b0; r_pend <= '0; r_isv <= '0; r_lvl <= '0;
            for (int i = 0; i < NumCtx*SrcWords; i++) r_en[i] <= '0;
            for (int i = 0; i < NumCtx; i++) r_thr[i] <= '0;
            r_ctx <= '0; r_lines <= '0;
        end else begin
            r_st <= n_st;
            r_done <= (r_st == ST_DONE);
            if (r_st == ST_CLEAR) r_clr <= r_clr + SrcW'(1);
            if (take) begin
                r_ctx <= '0; r_cctx <= cc[CtxW-1:0]; r_rdata <= '0;
                r_bad <= acc && mis;
                if (i_func == FN_LEVEL && i_source >= 6'd1 && i_source <= 6'(NumSrc)) begin
                    r_lvl[i_source] <= i_level;
                    if (i_level && !r_isv[i_source]) r_pend[i_source] <= 1'b1;
                end else if (acc && !mis) begin
                    if (is_pri) begin
                        if (!wr) r_rdata <= 32'(r_prio[pid[SrcW-1:0]]);
                    end else if (is_pen) begin
                        if (!wr) r_rdata <= r_pend[pw[WordW-1:0]*32 +: 32];
                    end else if (is_en) begin
                        if (wr) r_en[int'(ec)*SrcWords + int'(ew)] <=
                                   i_wdata & vmask(int'(ew));
                        else r_rdata <= r_en[int'(ec)*SrcWords + int'(ew)];
                    end else if (cr == 12'h0) begin
                        if (wr) r_thr[cc[CtxW-1:0]] <= i_wdata[PrioW-1:0];
                        else r_rdata <= 32'(r_thr[cc[CtxW-1:0]]);
                    end else if (wr) begin
                        if (i_wdata >= 32'd1 && i_wdata <= 32'(NumSrc) && r_isv[cid] &&
                            r_en[int'(cc[CtxW-1:0])*SrcWords + int'(cid >> 5)][cid[4:0]]) begin
                            r_isv[cid] <= 1'b0;
                            if (r_lvl[cid] && !r_pend[cid]) r_pend[cid] <= 1'b1;
                        end
                    end
                end
            end
            if (r_st == ST_CLAIM && rsp.done) begin
                r_rdata <= 32'(rsp.best);
                if (rsp.best != '0) begin
                    r_pend[rsp.best] <= 1'b0; r_isv[rsp.best] <= 1'b1;
                end
            end
            if (r_st == ST_LINES && rsp.done) begin
                r_lines[r_ctx] <= (rsp.best != '0);
                if (!last_ctx) r_ctx <= r_ctx + CtxW'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_rdata = r_rdata;
    assign o_irq_lines = r_lines;
    assign o_bad_access = r_bad;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_done |-> !busy)
        else $error("done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) (r_pend & r_isv) == '0)
        else $error("source both pending and in service");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_pend[0] && !r_isv[0])
        else $error("source zero active");
endmodule

@@ bench/testbench.sv @@
// Testbench for platform_interrupt_controller: random and directed bus reads,
// writes and source level updates, with a scoreboard that predicts each result word.
// Depends on plic_pkg and the RTL top level.
`timescale 1ns / 1ps
module testbench;
    import plic_pkg::*;

    localparam logic [25:0] ThrStride  = 26'h1000;
    localparam logic [25:0] EnStride   = 26'h80;
    localparam logic [25:0] ClaimOfs   = 26'h4;
    localparam int          ScanCycles = 1 + 8 * (NumSrc + 1) + (NumSrc + 1);

    typedef struct packed {
        logic [31:0] rdata;
        logic [7:0]  lines;
        logic        bad;
    } t_word;

    class plic_scoreboard;
        logic [PrioW-1:0]    prio [NumSrc+1];
        logic [31:0]         en_word [NumCtx][SrcWords];
        logic [PrioW-1:0]    thr [NumCtx];
        logic [NSrcBits-1:0] pend, insvc, lvl;
        t_word               exp_q[$];
        int                  errors;

        function new();
            foreach (prio[i]) prio[i] = '0;
            foreach (en_word[c, w]) en_word[c][w] = '0;
            foreach (thr[c]) thr[c] = '0;
            pend = '0; insvc = '0; lvl = '0;
            errors = 0;
        endfunction

        function logic is_enabled(int c, int id);
            return en_word[c][id / 32][id % 32];
        endfunction

        function int winner(int c);
            int best;
            int bestp;
            best = 0;
            bestp = thr[c];
            for (int id = 1; id <= NumSrc; id++)
                if (pend[id] && is_enabled(c, id) && prio[id] > bestp) begin
                    bestp = prio[id];
                    best = id;
                end
            return best;
        endfunction

        function void gate(int id);
            if (lvl[id] && !pend[id] && !insvc[id]) pend[id] = 1'b1;
        endfunction

        function void note_input(t_func fn, logic [25:0] off, logic [31:0] wd,
                                 logic [5:0] src, logic lv);
            t_word e;
            logic  wr;
            int    rel, cc, w, r, id;
            e = '0;
            wr = (fn == FN_WRITE);
            if (fn == FN_LEVEL) begin
                if (src >= 1 && src <= NumSrc) begin
                    lvl[src] = lv;
                    gate(src);
                end
            end else if (fn == FN_READ || fn == FN_WRITE) begin
                if (off[1:0] != 2'b00) begin
                    e.bad = 1'b1;
                end else if (off < PendBase) begin
                    id = int'(off >> 2);
                    if (id > NumSrc) e.bad = 1'b1;
                    else if (wr) begin
                        if (id != 0) prio[id] = wd[PrioW-1:0];
                    end else e.rdata = 32'(prio[id]);
                end else if (off < EnBase) begin
                    w = int'((off - PendBase) >> 2);
                    if (w >= SrcWords) e.bad = 1'b1;
                    else if (!wr) e.rdata = pend[w*32 +: 32];
                end else if (off < CtxBase) begin
                    rel = int'(off - EnBase);
                    cc = rel / EnStride;
                    w = (rel % EnStride) >> 2;
                    if (cc >= NumCtx || w >= SrcWords) e.bad = 1'b1;
                    else if (wr) en_word[cc][w] = (w == 0) ? (wd & 32'hFFFF_FFFE) : wd;
                    else e.rdata = en_word[cc][w];
                end else begin
                    rel = int'(off - CtxBase);
                    cc = rel / ThrStride;
                    r = rel % ThrStride;
                    if (cc >= NumCtx || (r != 0 && r != ClaimOfs)) e.bad = 1'b1;
                    else if (r == 0) begin
                        if (wr) thr[cc] = wd[PrioW-1:0];
                        else e.rdata = 32'(thr[cc]);
                    end else if (wr) begin
                        if (wd >= 1 && wd <= NumSrc && insvc[wd] && is_enabled(cc, wd)) begin
                            insvc[wd] = 1'b0;
                            gate(wd);
                        end
                    end else begin
                        id = winner(cc);
                        if (id != 0) begin
                            pend[id] = 1'b0;
                            insvc[id] = 1'b1;
                        end
                        e.rdata = 32'(id);
                    end
                end
                if (wr) e.rdata = '0;
            end
            for (int c = 0; c < NumCtx && c < 8; c++)
                if (winner(c) != 0) e.lines[c] = 1'b1;
            exp_q.push_back(e);
        endfunction

        function void check_result(logic [31:0] rd, logic [7:0] ln, logic bd);
            t_word e;
            if (exp_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (rd !== e.rdata) begin
                $error("rdata: expected %h, got %h", e.rdata, rd);
                errors++;
            end
            if (ln !== e.lines) begin
                $error("irq_lines: expected %h, got %h", e.lines, ln);
                errors++;
            end
            if (bd !== e.bad) begin
                $error("bad_access: expected %b, got %b", e.bad, bd);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_func;
    logic [25:0] i_offset;
    logic [31:0] i_wdata;
    logic [5:0]  i_source;
    logic        i_level;
    logic        o_done;
    logic [31:0] o_rdata;
    logic [7:0]  o_irq_lines;
    logic        o_bad_access;

    plic_scoreboard sb;
    int             taken_cnt;

    platform_interrupt_controller u_top (.*);

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_result(o_rdata, o_irq_lines, o_bad_access);
            if (start && !busy) begin
                sb.note_input(t_func'(i_func), i_offset, i_wdata, i_source, i_level);
                taken_cnt++;
            end
        end
    end

    task automatic send_word(t_func fn, logic [25:0] off, logic [31:0] wd,
                             logic [5:0] src, logic lv);
        int seen;
        int gap;
        seen = taken_cnt;
        i_func <= fn;
        i_offset <= off;
        i_wdata <= wd;
        i_source <= src;
        i_level <= lv;
        start <= 1'b1;
        do @(negedge i_clk); while (taken_cnt == seen);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic [25:0] prio_ofs(int id);
        return 26'(4 * id);
    endfunction

    function automatic logic [25:0] en_ofs(int c, int w);
        return 26'(EnBase + EnStride * c + 4 * w);
    endfunction

    function automatic logic [25:0] ctx_ofs(int c);
        return 26'(CtxBase + ThrStride * c);
    endfunction

    task automatic random_word();
        int    pick;
        int    c;
        pick = $urandom_range(0, 99);
        c = $urandom_range(0, NumCtx - 1);
        if (pick < 28)
            send_word(FN_LEVEL, 26'($urandom), $urandom, 6'($urandom), 1'($urandom));
        else if (pick < 42)
            send_word(FN_WRITE, prio_ofs($urandom_range(0, NumSrc)), $urandom,
                      6'($urandom), 1'($urandom));
        else if (pick < 50)
            send_word(FN_WRITE, en_ofs(c, $urandom_range(0, 1)), $urandom, 6'($urandom),
                      1'($urandom));
        else if (pick < 56)
            send_word(FN_WRITE, ctx_ofs(c), $urandom, 6'($urandom), 1'($urandom));
        else if (pick < 72)
            send_word(FN_READ, ctx_ofs(c) + ClaimOfs, $urandom, 6'($urandom),
                      1'($urandom));
        else if (pick < 86)
            send_word(FN_WRITE, ctx_ofs(c) + ClaimOfs,
                      ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, NumSrc),
                      6'($urandom), 1'($urandom));
        else if (pick < 92)
            send_word(FN_READ, ($urandom_range(0, 1) != 0) ? PendBase + 26'(4 * $urandom_range(0, 2))
                      : (($urandom_range(0, 1) != 0) ? prio_ofs($urandom_range(0, NumSrc))
                      : en_ofs(c, $urandom_range(0, 1))), $urandom, 6'($urandom),
                      1'($urandom));
        else
            send_word(t_func'($urandom_range(0, 3)), 26'($urandom), $urandom, 6'($urandom),
                      1'($urandom));
    endtask

    initial begin
        sb = new();
        taken_cnt = 0;
        start = 1'b0;
        i_func = FN_NONE;
        i_offset = '0;
        i_wdata = '0;
        i_source = '0;
        i_level = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: map corners, source 0, gateway and claim/complete cycle
        send_word(FN_READ, prio_ofs(0), '0, '0, 1'b0);
        send_word(FN_WRITE, prio_ofs(0), 32'hFFFF_FFFF, '0, 1'b0);
        send_word(FN_WRITE, prio_ofs(NumSrc), 32'hFFFF_FFFF, '0, 1'b0);
        send_word(FN_WRITE, prio_ofs(1), 32'h0000_0007, '0, 1'b0);
        send_word(FN_WRITE, en_ofs(0, 0), 32'hFFFF_FFFF, '0, 1'b0);
        send_word(FN_WRITE, en_ofs(NumCtx - 1, 1), 32'hFFFF_FFFF, '0, 1'b0);
        send_word(FN_LEVEL, '0, '0, 6'd0, 1'b1);
        send_word(FN_LEVEL, '0, '0, 6'd1, 1'b1);
        send_word(FN_LEVEL, '0, '0, 6'd63, 1'b1);
        send_word(FN_READ, PendBase, '0, '0, 1'b0);
        send_word(FN_READ, PendBase + 26'd4, '0, '0, 1'b0);
        send_word(FN_WRITE, PendBase, 32'hFFFF_FFFF, '0, 1'b0);
        send_word(FN_READ, ctx_ofs(0) + ClaimOfs, '0, '0, 1'b0);
        send_word(FN_WRITE, ctx_ofs(0) + ClaimOfs, 32'd1, '0, 1'b0);
        send_word(FN_LEVEL, '0, '0, 6'd1, 1'b0);
        send_word(FN_READ, ctx_ofs(NumCtx - 1) + ClaimOfs, '0, '0, 1'b0);
        send_word(FN_WRITE, ctx_ofs(NumCtx - 1), 32'hFFFF_FFFF, '0, 1'b0);
        send_word(FN_READ, ctx_ofs(NumCtx - 1), '0, '0, 1'b0);
        send_word(FN_WRITE, ctx_ofs(0) + ClaimOfs, 32'd0, '0, 1'b0);
        send_word(FN_WRITE, ctx_ofs(0) + ClaimOfs, 32'd64, '0, 1'b0);
        send_word(FN_READ, 26'h2, '0, '0, 1'b0);
        send_word(FN_READ, 26'h3FF_FFFF, '0, '0, 1'b0);
        send_word(FN_READ, ctx_ofs(NumCtx), '0, '0, 1'b0);
        send_word(FN_READ, ctx_ofs(0) + 26'h8, '0, '0, 1'b0);
        send_word(FN_NONE, 26'h3FF_FFFF, 32'hFFFF_FFFF, 6'h3F, 1'b1);

        for (int n = 0; n < 1625; n++) random_word();
        start <= 1'b0;

        while (sb.exp_q.size() != 0) @(negedge i_clk);
        repeat (ScanCycles) @(negedge i_clk);
        if (sb.exp_q.size() != 0) sb.errors++;
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/plic_pkg.sv
rtl/core/plic_scan.sv
rtl/core/platform_interrupt_controller.sv
bench/testbench.sv
